[rtl/wbcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbcd_pkg
// Shared constants and action codes of the weighted block cache directory.
// ----------------------------------------------------------------------------
package wbcd_pkg;

    localparam int MAX_BLOCKS_DEF  = 32;
    localparam int MAX_SPB_DEF     = 8;

    localparam int FUNC_W   = 2;
    localparam int SECTOR_W = 64;
    localparam int COUNT_W  = 16;
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 5;
    localparam int OFFSET_W = 3;
    localparam int WEIGHT_W = 32;
    localparam int SPB_W    = 4;
    localparam int NB_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DIRECT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_HIT       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FILL      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FWD_WRITE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FILL_FAIL = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FILL_DONE = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_NO_FILL   = 3'd7;

endpackage
`default_nettype wire

[rtl/weighted_block_cache_directory.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_block_cache_directory
// Tag and weighted replacement directory of a sector read cache.
// ----------------------------------------------------------------------------
// Request channel: i_valid / o_stall with func, start sector, count, fill_ok.
// Result channel: o_valid / i_stall, exactly one result per request.
// Configuration: i_cfg_valid / o_cfg_ready, index and data, written idle.
// A read walks the directory one entry per cycle through one shared
// compare / weight-update unit. A fill report, zero-length read or unknown
// func goes straight to the result; a direct read is decided at the first
// entry, a hit ends the walk at its entry, a write walks all blocks in use,
// and a miss runs hit search, a restoring divide for the base age term,
// aging with the minimum search, then invalidate.
// The result shows up in the same cycle that the next request can be taken.
// Only one request is processed at a time; o_stall is high while it runs.
// The result sits in an output register and holds while i_stall is high;
// a following request may still run and then waits in its last cycle until
// that register frees. Reset clears valid bits, weights and the pending
// fill; tags are loaded only when a fill succeeds, so no clearing pass.
// ----------------------------------------------------------------------------
module weighted_block_cache_directory #(
    parameter int MAX_BLOCKS = wbcd_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_SECTORS_PER_BLOCK = wbcd_pkg::MAX_SPB_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [wbcd_pkg::FUNC_W-1:0]      i_func,
    input  wire  [wbcd_pkg::SECTOR_W-1:0]    i_start_sector,
    input  wire  [wbcd_pkg::COUNT_W-1:0]     i_sector_count,
    input  wire                              i_fill_ok,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [wbcd_pkg::ACTION_W-1:0]    o_action,
    output logic [wbcd_pkg::INDEX_W-1:0]     o_block_index,
    output logic [wbcd_pkg::OFFSET_W-1:0]    o_sector_offset,
    output logic [wbcd_pkg::COUNT_W-1:0]     o_served_count,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [wbcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [wbcd_pkg::SECTOR_W-1:0]    i_cfg_data
);
    import wbcd_pkg::*;

    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int DIV_W = SPB_W + 8;
    localparam logic [3:0] DIV_LAST = 4'(DIV_W - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_HIT   = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_EVICT = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;
    localparam logic [2:0] ST_BASE  = 3'd7;

    localparam logic signed [WEIGHT_W:0] W_MAX = 33'sh0_7fff_ffff;
    localparam logic signed [WEIGHT_W:0] W_MIN = -33'sh0_8000_0000;

    logic [2:0]                 r_state;
    logic [SPB_W-1:0]           r_spb_cfg;
    logic [NB_W-1:0]            r_nb_cfg;
    logic [SECTOR_W-1:0]        r_dev;

    logic [SECTOR_W-1:0]        r_tag [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]      r_tag_valid;
    logic [WEIGHT_W-1:0]        r_weight [MAX_BLOCKS];

    logic                       r_fill_pending;
    logic [INDEX_W-1:0]         r_pend_blk;
    logic [SECTOR_W-1:0]        r_pend_sec;
    logic [COUNT_W-1:0]         r_pend_cnt;

    logic [SECTOR_W-1:0]        r_sec;
    logic [COUNT_W-1:0]         r_cnt;
    logic [CW-1:0]              r_idx;
    logic [BW-1:0]              r_best;
    logic signed [WEIGHT_W:0]   r_best_w;
    logic [WEIGHT_W-1:0]        r_base;
    logic [DIV_W-1:0]           r_quo;
    logic [CW-1:0]              r_rem;
    logic [3:0]                 r_div_cnt;

    logic                       r_out_valid;
    logic [ACTION_W-1:0]        r_act;
    logic [INDEX_W-1:0]         r_blk;
    logic [OFFSET_W-1:0]        r_off;
    logic [COUNT_W-1:0]         r_scnt;
    logic [ACTION_W-1:0]        r_res_act;
    logic [INDEX_W-1:0]         r_res_blk;
    logic [OFFSET_W-1:0]        r_res_off;
    logic [COUNT_W-1:0]         r_res_scnt;

    // effective configuration
    logic [SPB_W-1:0]           spb;
    logic [CW-1:0]              nb;
    always_comb begin
        if (r_spb_cfg == '0) spb = SPB_W'(1);
        else if (32'(r_spb_cfg) > MAX_SECTORS_PER_BLOCK)
            spb = SPB_W'(MAX_SECTORS_PER_BLOCK);
        else spb = r_spb_cfg;
        if (r_nb_cfg == '0) nb = CW'(1);
        else if (32'(r_nb_cfg) > MAX_BLOCKS) nb = CW'(MAX_BLOCKS);
        else nb = CW'(r_nb_cfg);
    end

    // base age term spb*256/nb: restoring divide, one quotient bit per cycle
    logic [CW:0]                rem_sh;
    logic                       div_ge;
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign div_ge = (rem_sh >= {1'b0, nb});

    // shared unit: one entry per cycle
    logic [BW-1:0]              idx;
    logic [SECTOR_W-1:0]        cur_tag;
    logic                       cur_valid;
    logic signed [WEIGHT_W-1:0] cur_w;
    logic [SECTOR_W-1:0]        diff;
    logic                       hit_match;
    logic                       wr_overlap;
    logic signed [WEIGHT_W:0]   aged;
    logic signed [WEIGHT_W:0]   age_raw;
    logic signed [WEIGHT_W-1:0] w_div;
    logic signed [WEIGHT_W:0]   hit_sum;
    logic [WEIGHT_W-1:0]        hit_w;
    logic [WEIGHT_W-1:0]        aged_w;

    assign idx       = r_idx[BW-1:0];
    assign cur_tag   = r_tag[idx];
    assign cur_valid = r_tag_valid[idx];
    assign cur_w     = $signed(r_weight[idx]);
    assign diff      = r_sec - cur_tag;

    function automatic logic overlaps(input logic [SECTOR_W-1:0] tag,
                                      input logic [SPB_W-1:0] s,
                                      input logic [SECTOR_W-1:0] sec,
                                      input logic [COUNT_W-1:0] cnt);
        logic [SECTOR_W-1:0] d1;
        logic [SECTOR_W-1:0] d2;
        d1 = sec - tag;
        d2 = tag - sec;
        if (cnt == '0) return 1'b0;
        if (sec >= tag) return d1 < SECTOR_W'(s);
        return d2 < SECTOR_W'(cnt);
    endfunction

    assign hit_match = cur_valid && (r_sec >= cur_tag) && (diff < SECTOR_W'(spb))
                       && ({48'd0, r_cnt} <= SECTOR_W'(spb) - diff);
    assign wr_overlap = cur_valid && overlaps(cur_tag, spb, r_sec, r_cnt);

    // truncating divide by 32: bias negatives before the shift
    assign w_div   = (cur_w + (cur_w[WEIGHT_W-1] ? 32'sd31 : 32'sd0)) >>> 5;
    assign age_raw = $signed({cur_w[WEIGHT_W-1], cur_w})
                     - ($signed({1'b0, r_base}) + $signed({w_div[WEIGHT_W-1], w_div}));
    always_comb begin
        if (age_raw > W_MAX) aged = W_MAX;
        else if (age_raw < W_MIN) aged = W_MIN;
        else aged = age_raw;
    end
    assign aged_w = aged[WEIGHT_W-1:0];

    assign hit_sum = (cur_w[WEIGHT_W-1] ? 33'sd0 : $signed({1'b0, cur_w}))
                     + $signed({9'd0, r_cnt, 8'd0});
    assign hit_w = (hit_sum > W_MAX) ? W_MAX[WEIGHT_W-1:0] : hit_sum[WEIGHT_W-1:0];

    logic last;
    assign last = (r_idx == nb - CW'(1));

    logic direct;
    logic [SECTOR_W-1:0] dev_left;
    assign dev_left = r_dev - r_sec;
    assign direct = (r_cnt > COUNT_W'(spb)) || ((r_cnt == COUNT_W'(spb)) && (spb > 1))
                    || (r_sec >= r_dev) || (SECTOR_W'(spb) > dev_left);

    assign o_stall         = (r_state != ST_IDLE);
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_action        = r_res_act;
    assign o_block_index   = r_res_blk;
    assign o_sector_offset = r_res_off;
    assign o_served_count  = r_res_scnt;

    // directory arrays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_valid <= '0;
            for (int k = 0; k < MAX_BLOCKS; k++) r_weight[k] <= '0;
        end else begin
            unique case (r_state)
                ST_CHECK: begin
                    if (hit_match && !direct) r_weight[idx] <= hit_w;
                end
                ST_AGE:   r_weight[idx] <= aged_w;
                ST_EVICT: r_tag_valid[r_best] <= 1'b0;
                ST_WRITE: begin
                    if (wr_overlap) r_tag_valid[idx] <= 1'b0;
                end
                ST_IDLE: begin
                    if (i_valid && !o_stall && i_func == FUNC_FILL && r_fill_pending
                        && i_fill_ok) begin
                        r_tag_valid[r_pend_blk[BW-1:0]] <= 1'b1;
                        r_weight[r_pend_blk[BW-1:0]] <=
                            WEIGHT_W'({r_pend_cnt, 8'd0});
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && !o_stall && i_func == FUNC_FILL
            && r_fill_pending && i_fill_ok)
            r_tag[r_pend_blk[BW-1:0]] <= r_pend_sec;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_fill_pending <= 1'b0;
            r_pend_blk     <= '0;
            r_pend_sec     <= '0;
            r_pend_cnt     <= '0;
            r_spb_cfg      <= SPB_W'(8);
            r_nb_cfg       <= NB_W'(32);
            r_dev          <= '0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            CFG_SPB: r_spb_cfg <= i_cfg_data[SPB_W-1:0];
                            CFG_NB:  r_nb_cfg  <= i_cfg_data[NB_W-1:0];
                            CFG_DEV: r_dev     <= i_cfg_data;
                            default: ;
                        endcase
                    end
                    if (i_valid && !o_stall) begin
                        r_sec  <= i_start_sector;
                        r_cnt  <= i_sector_count;
                        r_idx  <= '0;
                        r_blk  <= '0;
                        r_off  <= '0;
                        r_scnt <= '0;
                        r_act  <= ACT_NONE;
                        unique case (i_func)
                            FUNC_READ: begin
                                if (i_sector_count == '0) r_state <= ST_DONE;
                                else r_state <= ST_CHECK;
                            end
                            FUNC_WRITE: r_state <= ST_WRITE;
                            FUNC_FILL: begin
                                r_state <= ST_DONE;
                                if (!r_fill_pending) r_act <= ACT_NO_FILL;
                                else begin
                                    r_fill_pending <= 1'b0;
                                    r_act  <= i_fill_ok ? ACT_FILL_DONE : ACT_FILL_FAIL;
                                    r_blk  <= r_pend_blk;
                                    r_scnt <= r_pend_cnt;
                                end
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_CHECK: begin
                    r_best   <= '0;
                    r_best_w <= W_MAX;
                    if (direct) begin
                        r_act   <= ACT_DIRECT;
                        r_scnt  <= r_cnt;
                        r_state <= ST_DONE;
                    end else if (hit_match) begin
                        r_act   <= ACT_HIT;
                        r_blk   <= INDEX_W'(idx);
                        r_off   <= diff[OFFSET_W-1:0];
                        r_scnt  <= r_cnt;
                        r_state <= ST_DONE;
                    end else if (last) begin
                        r_idx     <= '0;
                        r_quo     <= DIV_W'({spb, 8'd0});
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= ST_BASE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_BASE: begin
                    r_rem     <= div_ge ? CW'(rem_sh - {1'b0, nb}) : rem_sh[CW-1:0];
                    r_quo     <= {r_quo[DIV_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == DIV_LAST) begin
                        r_base  <= WEIGHT_W'({r_quo[DIV_W-2:0], div_ge});
                        r_state <= ST_AGE;
                    end
                end
                ST_AGE: begin
                    if (aged < r_best_w) begin
                        r_best_w <= aged;
                        r_best   <= idx;
                    end
                    if (last) r_state <= ST_EVICT;
                    else r_idx <= r_idx + CW'(1);
                end
                ST_EVICT: begin
                    r_fill_pending <= 1'b1;
                    r_pend_blk     <= INDEX_W'(r_best);
                    r_pend_sec     <= r_sec;
                    r_pend_cnt     <= r_cnt;
                    r_act          <= ACT_FILL;
                    r_blk          <= INDEX_W'(r_best);
                    r_scnt         <= COUNT_W'(spb);
                    r_state        <= ST_DONE;
                end
                ST_WRITE: begin
                    if (last) begin
                        if (r_fill_pending && overlaps(r_pend_sec, spb, r_sec, r_cnt))
                            r_fill_pending <= 1'b0;
                        r_act   <= ACT_FWD_WRITE;
                        r_scnt  <= r_cnt;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_DONE: begin
                    // wait here while the previous result is still held
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_res_act   <= r_act;
                        r_res_blk   <= r_blk;
                        r_res_off   <= r_off;
                        r_res_scnt  <= r_scnt;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
